// File: rtl/core/msfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msfs_pkg
// Shared types and constants for the multichannel smoothing frame sender.
// ----------------------------------------------------------------------------
package msfs_pkg;

   localparam int CHANNEL_W  = 3;
   localparam int SAMPLE_W   = 12;
   localparam int BYTE_W     = 8;
   localparam int LVL_EXT_W  = 16;

   localparam int CHANNELS_DEFAULT    = 6;
   localparam int SAMPLE_BITS_DEFAULT = 12;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int LEVEL_RESET = 2048;

   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [SAMPLE_W-1:0]  sample;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic              frame_end;
   } rsp_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [SAMPLE_W-1:0]  sample;
      logic                 last;
   } cmd_type;

endpackage

// File: rtl/core/msfs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msfs_front
// Classifies incoming samples: drops unknown channels, tags the last channel.
// ----------------------------------------------------------------------------
module msfs_front #(
   parameter int CHANNELS = msfs_pkg::CHANNELS_DEFAULT
) (
   input  logic             push,
   input  msfs_pkg::req_type req_item,
   output logic             q_push,
   output msfs_pkg::cmd_type q_cmd
);
   import msfs_pkg::*;

   logic in_range;
   logic is_last;

   always_comb begin
      in_range      = 32'(req_item.channel) < CHANNELS;
      is_last       = 32'(req_item.channel) == (CHANNELS - 1);
      q_push        = push && in_range;
      q_cmd.channel = req_item.channel;
      q_cmd.sample  = req_item.sample;
      q_cmd.last    = is_last;
   end

endmodule

// File: rtl/core/msfs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msfs_queue
// Short flop queue of classified items between front and back.
// ----------------------------------------------------------------------------
module msfs_queue #(
   parameter int DEPTH = msfs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  msfs_pkg::cmd_type wr_cmd,
   output logic              full,
   output logic              valid,
   output msfs_pkg::cmd_type rd_cmd,
   input  logic              pop
);
   import msfs_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   always_comb begin
      full    = count_ff == CNT_W'(DEPTH);
      valid   = count_ff != '0;
      rd_cmd  = slot_ff[rd_ptr_ff];
      do_push = push && !full;
      do_pop  = pop && valid;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/core/msfs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msfs_back
// Updates the per-channel smoothed levels and streams out the frame bytes.
// ----------------------------------------------------------------------------
module msfs_back #(
   parameter int CHANNELS    = msfs_pkg::CHANNELS_DEFAULT,
   parameter int SAMPLE_BITS = msfs_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  msfs_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              empty,
   input  logic              pop,
   output msfs_pkg::rsp_type rsp_item
);
   import msfs_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ACC_W = SAMPLE_BITS + 3;
   localparam logic [SAMPLE_BITS-1:0] QUANT_MASK = {{(SAMPLE_BITS-2){1'b1}}, 2'b00};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HEAD,
      ST_LEVEL,
      ST_SUM
   } state_type;

   state_type               state_ff, state_in;
   logic [SAMPLE_BITS-1:0]  levels_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0]  levels_in [CHANNELS];
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    hi_ff, hi_in;
   logic [1:0]              head_ff, head_in;
   logic [BYTE_W-1:0]       sum_ff, sum_in;
   logic                    out_valid_ff, out_valid_in;
   rsp_type                 out_ff, out_in;

   logic [IDX_W-1:0]        rd_idx;
   logic [SAMPLE_BITS-1:0]  old_lvl;
   logic [LVL_EXT_W-1:0]    lvl_ext;
   logic [SAMPLE_BITS-1:0]  sample_lvl;
   logic [ACC_W-1:0]        acc;
   logic [SAMPLE_BITS-1:0]  new_lvl;
   logic                    slot_free;
   logic                    emit;
   logic [BYTE_W-1:0]       emit_byte;
   logic                    emit_end;

   always_comb begin
      rd_idx     = (state_ff == ST_IDLE) ? IDX_W'(q_cmd.channel) : idx_ff;
      old_lvl    = levels_ff[rd_idx];
      lvl_ext    = LVL_EXT_W'(old_lvl);
      sample_lvl = SAMPLE_BITS'(q_cmd.sample);
      acc        = (ACC_W'(old_lvl) << 3) - ACC_W'(old_lvl) + ACC_W'(sample_lvl);
      new_lvl    = SAMPLE_BITS'(acc >> 3) & QUANT_MASK;
      slot_free  = !out_valid_ff || pop;

      state_in  = state_ff;
      levels_in = levels_ff;
      idx_in    = idx_ff;
      hi_in     = hi_ff;
      head_in   = head_ff;
      sum_in    = sum_ff;
      q_pop     = 1'b0;
      emit      = 1'b0;
      emit_byte = '0;
      emit_end  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop             = 1'b1;
               levels_in[rd_idx] = new_lvl;
               if (q_cmd.last) begin
                  state_in = ST_HEAD;
                  head_in  = '0;
                  sum_in   = '0;
               end
            end
         end
         ST_HEAD: begin
            if (slot_free) begin
               emit = 1'b1;
               case (head_ff)
                  2'd0:    emit_byte = SYNC_FIRST;
                  2'd1:    emit_byte = SYNC_SECOND;
                  default: emit_byte = BYTE_W'(CHANNELS);
               endcase
               sum_in  = sum_ff ^ emit_byte;
               head_in = head_ff + 1'b1;
               if (head_ff == 2'd2) begin
                  state_in = ST_LEVEL;
                  idx_in   = '0;
                  hi_in    = 1'b1;
               end
            end
         end
         ST_LEVEL: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_byte = hi_ff ? lvl_ext[15:8] : lvl_ext[7:0];
               sum_in    = sum_ff ^ emit_byte;
               hi_in     = !hi_ff;
               if (!hi_ff) begin
                  if (idx_ff == IDX_W'(CHANNELS - 1)) begin
                     state_in = ST_SUM;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            end
         end
         ST_SUM: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_byte = sum_ff;
               emit_end  = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_in.frame_byte = emit_byte;
         out_in.frame_end  = emit_end;
         out_valid_in      = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end

      empty    = !out_valid_ff;
      rsp_item = out_ff;
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      idx_ff  <= idx_in;
      hi_ff   <= hi_in;
      head_ff <= head_in;
      sum_ff  <= sum_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            levels_ff[i] <= SAMPLE_BITS'(LEVEL_RESET);
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         levels_ff    <= levels_in;
      end
   end

endmodule

// File: rtl/core/multichannel_smoothing_frame_sender_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_smoothing_frame_sender_core
// Per-channel first-order smoothing with a sync/count/levels/XOR byte frame.
// ----------------------------------------------------------------------------
// Each item carries a channel number and a sample. Items with a channel of
// CHANNELS or more are taken and dropped. Others enter a two-entry queue;
// the back end updates that channel's level as it pops the item. When the
// item is for the last channel, the back end then sends 3 + 2*CHANNELS + 1
// bytes, one per cycle while pop keeps up, and takes no further item from
// the queue until the checksum byte is in the output register. The byte
// sequencer and the single read port on the level registers bound how fast
// a full scan of CHANNELS samples goes through.
// ----------------------------------------------------------------------------
module multichannel_smoothing_frame_sender_core #(
   parameter int CHANNELS    = msfs_pkg::CHANNELS_DEFAULT,
   parameter int SAMPLE_BITS = msfs_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  msfs_pkg::req_type req_item,
   output logic              empty,
   input  logic              pop,
   output msfs_pkg::rsp_type rsp_item
);
   import msfs_pkg::*;

   logic    q_push;
   cmd_type q_wr_cmd;
   logic    q_valid;
   cmd_type q_rd_cmd;
   logic    q_pop;

   msfs_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .push     (push),
      .req_item (req_item),
      .q_push   (q_push),
      .q_cmd    (q_wr_cmd)
   );

   msfs_queue #(
      .DEPTH (QUEUE_DEPTH_DEFAULT)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_cmd (q_wr_cmd),
      .full   (full),
      .valid  (q_valid),
      .rd_cmd (q_rd_cmd),
      .pop    (q_pop)
   );

   msfs_back #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_cmd    (q_rd_cmd),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule

// File: sim/tb_multichannel_smoothing_frame_sender_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multichannel_smoothing_frame_sender_core
// Self-checking bench for the per-channel smoothing and byte frame sender.
// ----------------------------------------------------------------------------
// Samples go in through the push/full queue port. A local copy of the
// smoothed levels is updated per accepted in-range item, each scan-completing
// item queues the sixteen frame bytes it must produce. The result side pops
// with random stalls and checks every byte and end flag in order.
// ----------------------------------------------------------------------------
module tb_multichannel_smoothing_frame_sender_core;

   import msfs_pkg::*;

   localparam int NUM_CH  = CHANNELS_DEFAULT;
   localparam int MAX_GAP = 5;

   typedef enum int {SMP_RANDOM, SMP_TOP, SMP_ZERO, SMP_NEAR_END} sample_mode_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_item;
   logic    empty;
   logic    pop;
   rsp_type rsp_item;

   logic [SAMPLE_W-1:0] level_track [NUM_CH];
   rsp_type             frame_due [$];
   int                  errors = 0;
   int                  live_samples = 0;
   bit                  no_idle = 1'b0;

   multichannel_smoothing_frame_sender_core dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   always #6 clock = ~clock;

   task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic last,
                             inout logic [BYTE_W-1:0] chk);
      rsp_type r;
      r.frame_byte = b;
      r.frame_end  = last;
      frame_due.push_back(r);
      chk ^= b;
   endtask

   task automatic smooth_and_frame(input req_type it);
      int unsigned         acc;
      logic [BYTE_W-1:0]   chk;
      if (it.channel >= NUM_CH)
         return;
      acc = (int'(level_track[it.channel]) * 7 + int'(it.sample)) / 8;
      level_track[it.channel] = SAMPLE_W'(acc) & ~SAMPLE_W'(3);
      if (it.channel != NUM_CH - 1)
         return;
      chk = '0;
      queue_byte(SYNC_FIRST, 1'b0, chk);
      queue_byte(SYNC_SECOND, 1'b0, chk);
      queue_byte(BYTE_W'(NUM_CH), 1'b0, chk);
      for (int c = 0; c < NUM_CH; c++) begin
         queue_byte(BYTE_W'(level_track[c] >> 8), 1'b0, chk);
         queue_byte(level_track[c][7:0], 1'b0, chk);
      end
      queue_byte(chk, 1'b1, chk);
   endtask

   task automatic send_sample(input int ch, input int smp);
      int      gap;
      req_type it;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      it.channel = CHANNEL_W'(ch);
      it.sample  = SAMPLE_W'(smp);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item <= it;
      push     <= 1'b1;
      do @(posedge clock); while (full);
      smooth_and_frame(it);
      if (ch < NUM_CH)
         live_samples++;
   endtask

   function automatic int pick_sample(input sample_mode_type m);
      case (m)
         SMP_TOP:      return 4095;
         SMP_ZERO:     return 0;
         SMP_NEAR_END: return $urandom_range(0, 1) ? $urandom_range(0, 15)
                                                   : $urandom_range(4080, 4095);
         default:      return $urandom_range(0, 4095);
      endcase
   endfunction

   task automatic wait_drained();
      push <= 1'b0;
      while (frame_due.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_reset_frame();
      send_sample(NUM_CH - 1, 2048);
      wait_drained();
   endtask

   task automatic test_field_extremes();
      send_sample(0, 'hFFF);
      send_sample(1, 'h000);
      send_sample(2, 'hAAA);
      send_sample(3, 'h555);
      send_sample(4, 'hFFF);
      send_sample(5, 'h000);
      send_sample(5, 'hFFF);
      send_sample(0, 'h000);
      send_sample(5, 'h001);
   endtask

   task automatic test_ignored_channels();
      send_sample(6, 'hFFF);
      send_sample(7, 'h000);
      send_sample(7, 'hFFF);
      send_sample(6, 'h000);
      send_sample(NUM_CH - 1, 'h800);
   endtask

   task automatic test_random_scans(input int target);
      int              stop_at;
      int              kind;
      int              run;
      int              lo;
      int              hi;
      sample_mode_type mode;
      stop_at = live_samples + target;
      while (live_samples < stop_at) begin
         no_idle = ($urandom_range(0, 5) == 0);
         mode    = sample_mode_type'($urandom_range(0, 3));
         run     = $urandom_range(1, 8);
         kind    = $urandom_range(0, 9);
         if (kind < 7) begin
            repeat (run)
               for (int c = 0; c < NUM_CH; c++)
                  send_sample(c, pick_sample(mode));
         end else if (kind < 9) begin
            lo = $urandom_range(0, NUM_CH - 1);
            hi = $urandom_range(lo, NUM_CH - 1);
            for (int c = lo; c <= hi; c++)
               if ($urandom_range(0, 3) != 0)
                  send_sample(c, pick_sample(mode));
         end else begin
            repeat (run)
               send_sample($urandom_range(0, 7), $urandom_range(0, 4095));
         end
      end
      no_idle = 1'b0;
   endtask

   task automatic test_drain_pause();
      wait_drained();
      repeat ($urandom_range(1, 20)) @(posedge clock);
      for (int c = 0; c < NUM_CH; c++)
         send_sample(c, $urandom_range(0, 4095));
   endtask

   task automatic finish_run();
      int n;
      push <= 1'b0;
      n = 0;
      while (frame_due.size() != 0 && n < 20000) begin
         @(posedge clock);
         n++;
      end
      repeat (40) @(posedge clock);
      if (frame_due.size() != 0) begin
         $error("%0d frame bytes never arrived", frame_due.size());
         errors++;
      end
      if (errors == 0)
         $display("[multichannel_smoothing_frame_sender_core] OK");
      else
         $display("[multichannel_smoothing_frame_sender_core] ERROR");
      $finish;
   endtask

   initial begin
      reset    = 1'b1;
      push     = 1'b0;
      req_item = '0;
      for (int c = 0; c < NUM_CH; c++)
         level_track[c] = SAMPLE_W'(LEVEL_RESET);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_frame();
      test_field_extremes();
      test_ignored_channels();
      test_random_scans(200);
      test_drain_pause();
      test_random_scans(200);
      finish_run();
   end

   // ------------------------------------------------------------------------
   // Result side: random pop stalls, in-order byte check
   // ------------------------------------------------------------------------
   initial begin
      rsp_type got;
      rsp_type want;
      int      stall;
      pop = 1'b0;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         got = rsp_item;
         if (frame_due.size() == 0) begin
            $error("unexpected item: frame_byte %0h frame_end %0b",
                   got.frame_byte, got.frame_end);
            errors++;
         end else begin
            want = frame_due.pop_front();
            if (got.frame_byte !== want.frame_byte) begin
               $error("frame_byte mismatch: expected %0h, got %0h",
                      want.frame_byte, got.frame_byte);
               errors++;
            end
            if (got.frame_end !== want.frame_end) begin
               $error("frame_end mismatch: expected %0b, got %0b",
                      want.frame_end, got.frame_end);
               errors++;
            end
         end
      end
   end

   initial begin
      #3_600_000;
      $display("[multichannel_smoothing_frame_sender_core] ERROR");
      $finish;
   end

endmodule
